[rtl/core/cvu_pkg.sv]
// ---------------------------------------------------------------------------
// cvu_pkg
// Shared types, constants and the CORDIC arctangent table of the camera view
// update block.
// ---------------------------------------------------------------------------
package cvu_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_TBL_LEN    = 24;
   localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > CORDIC_TBL_LEN) ?
                                      CORDIC_TBL_LEN : CORDIC_ITERATIONS;
   localparam int CORDIC_CNT_W      = $clog2(CORDIC_STEPS);

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z = 2'd3;

   localparam logic [15:0] SPEED_RESET = 16'd256;

   typedef struct packed {
      logic        [15:0] delta_time;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] pitch_step;
      logic signed [15:0] yaw_step;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [31:0] tx;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [31:0] ty;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic signed [31:0] tz;
   } rsp_word_type;

   typedef struct packed {
      logic        start;
      logic [15:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
   } cordic_rsp_type;

   // Arctangent of 2^-i in 32-bit turns.
   function automatic logic signed [32:0] cordic_atan(input logic [4:0] idx);
      logic signed [32:0] v;
      unique case (idx)
         5'd0:  v = 33'sd536870912;
         5'd1:  v = 33'sd316933406;
         5'd2:  v = 33'sd167458907;
         5'd3:  v = 33'sd85004760;
         5'd4:  v = 33'sd42667331;
         5'd5:  v = 33'sd21354465;
         5'd6:  v = 33'sd10679838;
         5'd7:  v = 33'sd5340245;
         5'd8:  v = 33'sd2670163;
         5'd9:  v = 33'sd1335087;
         5'd10: v = 33'sd667544;
         5'd11: v = 33'sd333772;
         5'd12: v = 33'sd166886;
         5'd13: v = 33'sd83443;
         5'd14: v = 33'sd41722;
         5'd15: v = 33'sd20861;
         5'd16: v = 33'sd10430;
         5'd17: v = 33'sd5215;
         5'd18: v = 33'sd2608;
         5'd19: v = 33'sd1304;
         5'd20: v = 33'sd652;
         5'd21: v = 33'sd326;
         5'd22: v = 33'sd163;
         5'd23: v = 33'sd81;
         default: v = 33'sd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/cvu_req_if.sv]
// ---------------------------------------------------------------------------
// cvu_req_if
// Valid/ready channel carrying one camera update request word.
// ---------------------------------------------------------------------------
interface cvu_req_if
   import cvu_pkg::*;
();
   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

[rtl/core/cvu_rsp_if.sv]
// ---------------------------------------------------------------------------
// cvu_rsp_if
// Valid/ready channel carrying one view matrix word.
// ---------------------------------------------------------------------------
interface cvu_rsp_if
   import cvu_pkg::*;
();
   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

[rtl/core/cvu_cordic.sv]
// ---------------------------------------------------------------------------
// cvu_cordic
// Iterative rotation-mode CORDIC giving sine and cosine of a 16-bit binary
// angle in Q1.14, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module cvu_cordic
   import cvu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);

   localparam logic signed [32:0] QUARTER = 33'sd1073741824;
   localparam logic signed [32:0] HALF    = 33'sd2147483648;

   logic                     busy_ff, busy_in;
   logic                     fin_ff, fin_in;
   logic                     flip_ff, flip_in;
   logic [CORDIC_CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [33:0]       x_ff, x_in, y_ff, y_in;
   logic signed [32:0]       z_ff, z_in;
   logic signed [32:0]       z_start;
   logic signed [33:0]       sh_x, sh_y;
   logic signed [32:0]       at;
   logic signed [15:0]       cos_q, sin_q;

   function automatic logic signed [15:0] q30_to_q14(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) begin
         return 16'sd16384;
      end
      if (t < -34'sd16384) begin
         return -16'sd16384;
      end
      return 16'(t);
   endfunction

   assign z_start = {req.angle[15], req.angle, 16'h0000};
   assign sh_x    = x_ff >>> cnt_ff;
   assign sh_y    = y_ff >>> cnt_ff;
   assign at      = cordic_atan(5'(cnt_ff));

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (req.start) begin
         // Fold into a quarter turn either side of zero; the half-turn shift
         // is undone by negating both results.
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = CORDIC_GAIN_Q30;
         y_in    = 34'sd0;
         if (z_start > QUARTER) begin
            z_in    = z_start - HALF;
            flip_in = 1'b1;
         end else if (z_start < -QUARTER) begin
            z_in    = z_start + HALF;
            flip_in = 1'b1;
         end else begin
            z_in    = z_start;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - sh_y;
            y_in = y_ff + sh_x;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + sh_y;
            y_in = y_ff - sh_x;
            z_in = z_ff + at;
         end
         if (cnt_ff == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end else begin
            cnt_in = cnt_ff + CORDIC_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign cos_q = q30_to_q14(x_ff);
   assign sin_q = q30_to_q14(y_ff);

   assign rsp.done   = fin_ff;
   assign rsp.cosine = flip_ff ? -cos_q : cos_q;
   assign rsp.sine   = flip_ff ? -sin_q : sin_q;

endmodule

[rtl/core/camera_view_update.sv]
// ---------------------------------------------------------------------------
// camera_view_update
// First-person camera: moves and turns the kept camera and emits its 3x4
// fixed-point view matrix.
// ---------------------------------------------------------------------------
// One request word is taken at a time; ready is high only while the block is
// idle, and a request that neither moves nor turns the camera produces no
// response word and returns to idle at once. A turn-only request runs two
// CORDIC passes, pitch then yaw, then the matrix products and the translation
// dot products on the shared 18x33 multiplier. A request that moves first
// runs the bit-serial square root and one restoring division per axis. The
// response word is held until taken. A write to a start register loads that
// position axis at once.
// ---------------------------------------------------------------------------
module camera_view_update
   import cvu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   cvu_req_if.sink              req_ch,
   cvu_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_SQ_MUL  = 5'd1;
   localparam logic [4:0] S_SQ_ACC  = 5'd2;
   localparam logic [4:0] S_SC_MUL  = 5'd3;
   localparam logic [4:0] S_SC_ACC  = 5'd4;
   localparam logic [4:0] S_SQRT    = 5'd5;
   localparam logic [4:0] S_AX_MUL  = 5'd6;
   localparam logic [4:0] S_AX_LOAD = 5'd7;
   localparam logic [4:0] S_AX_DIV  = 5'd8;
   localparam logic [4:0] S_AX_UPD  = 5'd9;
   localparam logic [4:0] S_CP_GO   = 5'd10;
   localparam logic [4:0] S_CP_RUN  = 5'd11;
   localparam logic [4:0] S_CY_GO   = 5'd12;
   localparam logic [4:0] S_CY_RUN  = 5'd13;
   localparam logic [4:0] S_PR_MUL  = 5'd14;
   localparam logic [4:0] S_PR_ACC  = 5'd15;
   localparam logic [4:0] S_TR_MUL  = 5'd16;
   localparam logic [4:0] S_TR_ACC  = 5'd17;
   localparam logic [4:0] S_TR_END  = 5'd18;
   localparam logic [4:0] S_OUT     = 5'd19;

   localparam logic [5:0] SQRT_LAST = 6'd23;
   localparam logic [5:0] DIV_LAST  = 6'd47;
   localparam logic [1:0] AX_LAST   = 2'd2;

   logic [4:0]         state_ff, state_in;
   logic [1:0]         ax_ff, ax_in, row_ff, row_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [15:0]        speed_ff, speed_in;
   logic [15:0]        pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic [15:0]        dt_ff, dt_in;
   logic signed [15:0] dir_ff [3];
   logic signed [15:0] dir_in [3];
   logic [31:0]        sq_ff, sq_in, scale_ff, scale_in;
   logic [47:0]        rem_ff, rem_in, root_ff, root_in;
   logic [23:0]        drem_ff, drem_in;
   logic [47:0]        dquo_ff, dquo_in;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [15:0] sp_ff, sp_in, cp_ff, cp_in, sy_ff, sy_in, cy_ff, cy_in;
   logic signed [15:0] rowm_ff [9];
   logic signed [15:0] rowm_in [9];
   logic signed [48:0] acc_ff, acc_in;
   logic signed [31:0] t_ff [3];
   logic signed [31:0] t_in [3];

   logic signed [17:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [16:0] dext, absd;
   logic signed [15:0] opa, opb;
   logic [3:0]         ridx;
   logic [47:0]        bitv, trial;
   logic [24:0]        dsh;
   logic signed [49:0] magx, psum, tv;
   logic signed [50:0] pv;
   logic               req_acc;

   cordic_req_type     cor_req;
   cordic_rsp_type     cor_rsp;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -50'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   cvu_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cor_req),
      .rsp   (cor_rsp)
   );

   assign cor_req.start = (state_ff == S_CP_GO) || (state_ff == S_CY_GO);
   assign cor_req.angle = (state_ff == S_CY_GO) ? yaw_ff : pitch_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_OUT);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign dext = 17'(dir_ff[ax_ff]);
   assign absd = dext[16] ? -dext : dext;
   assign ridx = 4'(row_ff) * 4'd3 + 4'(ax_ff);

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin opa = sy_ff; opb = sp_ff; end
         2'd1: begin opa = cy_ff; opb = sp_ff; end
         2'd2: begin opa = sy_ff; opb = cp_ff; end
         2'd3: begin opa = cp_ff; opb = cy_ff; end
         default: begin opa = sy_ff; opb = sp_ff; end
      endcase
   end

   // The one multiplier, shared by every product of the sequence.
   always_comb begin
      mul_a = 18'sd0;
      mul_b = 33'sd0;
      unique case (state_ff)
         S_SQ_MUL: begin
            mul_a = 18'(dir_ff[ax_ff]);
            mul_b = 33'(dir_ff[ax_ff]);
         end
         S_SC_MUL: begin
            mul_a = {2'b00, dt_ff};
            mul_b = {17'd0, speed_ff};
         end
         S_AX_MUL: begin
            mul_a = {1'b0, absd};
            mul_b = {1'b0, scale_ff};
         end
         S_PR_MUL: begin
            mul_a = 18'(opa);
            mul_b = 33'(opb);
         end
         S_TR_MUL: begin
            mul_a = 18'(rowm_ff[ridx]);
            mul_b = 33'(pos_ff[ax_ff]);
         end
         default: begin
            mul_a = 18'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   assign prod_in = 51'(mul_a) * 51'(mul_b);

   assign bitv  = 48'd1 << (6'd46 - {cnt_ff[4:0], 1'b0});
   assign trial = root_ff + bitv;
   assign dsh   = {drem_ff, dquo_ff[47]};
   assign magx  = signed'({2'b00, dquo_ff});
   assign psum  = 50'(pos_ff[ax_ff]) + (dir_ff[ax_ff][15] ? -magx : magx);
   assign tv    = (50'sd8192 - 50'(acc_ff)) >>> 14;
   assign pv    = (prod_ff + 51'sd8192) >>> 14;

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      speed_in = speed_ff;
      pitch_in = pitch_ff;
      yaw_in   = yaw_ff;
      pos_in   = pos_ff;
      dt_in    = dt_ff;
      dir_in   = dir_ff;
      sq_in    = sq_ff;
      scale_in = scale_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      drem_in  = drem_ff;
      dquo_in  = dquo_ff;
      sp_in    = sp_ff;
      cp_in    = cp_ff;
      sy_in    = sy_ff;
      cy_in    = cy_ff;
      rowm_in  = rowm_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               dt_in     = req_ch.word.delta_time;
               dir_in[0] = req_ch.word.dir_x;
               dir_in[1] = req_ch.word.dir_y;
               dir_in[2] = req_ch.word.dir_z;
               pitch_in  = pitch_ff + req_ch.word.pitch_step;
               yaw_in    = yaw_ff + req_ch.word.yaw_step;
               ax_in     = 2'd0;
               sq_in     = 32'd0;
               if ((req_ch.word.dir_x != 16'sd0) || (req_ch.word.dir_y != 16'sd0) ||
                   (req_ch.word.dir_z != 16'sd0)) begin
                  state_in = S_SQ_MUL;
               end else if ((req_ch.word.pitch_step != 16'sd0) ||
                            (req_ch.word.yaw_step != 16'sd0)) begin
                  state_in = S_CP_GO;
               end
            end
         end
         S_SQ_MUL: state_in = S_SQ_ACC;
         S_SQ_ACC: begin
            sq_in = sq_ff + prod_ff[31:0];
            if (ax_ff == AX_LAST) begin
               ax_in    = 2'd0;
               state_in = S_SC_MUL;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_SQ_MUL;
            end
         end
         S_SC_MUL: state_in = S_SC_ACC;
         S_SC_ACC: begin
            scale_in = prod_ff[31:0];
            rem_in   = {sq_ff, 16'h0000};
            root_in  = 48'd0;
            cnt_in   = 6'd0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            if (cnt_ff == SQRT_LAST) begin
               state_in = S_AX_MUL;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_AX_MUL: state_in = S_AX_LOAD;
         S_AX_LOAD: begin
            dquo_in  = prod_ff[47:0];
            drem_in  = 24'd0;
            cnt_in   = 6'd0;
            state_in = S_AX_DIV;
         end
         S_AX_DIV: begin
            // Restoring division by the direction length, one quotient bit a cycle.
            if (dsh >= {1'b0, root_ff[23:0]}) begin
               drem_in = 24'(dsh - {1'b0, root_ff[23:0]});
               dquo_in = {dquo_ff[46:0], 1'b1};
            end else begin
               drem_in = dsh[23:0];
               dquo_in = {dquo_ff[46:0], 1'b0};
            end
            if (cnt_ff == DIV_LAST) begin
               state_in = S_AX_UPD;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_AX_UPD: begin
            pos_in[ax_ff] = sat32(psum);
            if (ax_ff == AX_LAST) begin
               ax_in    = 2'd0;
               state_in = S_CP_GO;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_AX_MUL;
            end
         end
         S_CP_GO: state_in = S_CP_RUN;
         S_CP_RUN: begin
            if (cor_rsp.done) begin
               sp_in    = cor_rsp.sine;
               cp_in    = cor_rsp.cosine;
               state_in = S_CY_GO;
            end
         end
         S_CY_GO: state_in = S_CY_RUN;
         S_CY_RUN: begin
            if (cor_rsp.done) begin
               sy_in      = cor_rsp.sine;
               cy_in      = cor_rsp.cosine;
               rowm_in[0] = cor_rsp.cosine;
               rowm_in[1] = 16'sd0;
               rowm_in[2] = -cor_rsp.sine;
               rowm_in[4] = cp_ff;
               rowm_in[7] = -sp_ff;
               cnt_in     = 6'd0;
               state_in   = S_PR_MUL;
            end
         end
         S_PR_MUL: state_in = S_PR_ACC;
         S_PR_ACC: begin
            unique case (cnt_ff[1:0])
               2'd0: rowm_in[3] = 16'(pv);
               2'd1: rowm_in[5] = 16'(pv);
               2'd2: rowm_in[6] = 16'(pv);
               2'd3: rowm_in[8] = 16'(pv);
               default: rowm_in[3] = 16'(pv);
            endcase
            if (cnt_ff[1:0] == 2'd3) begin
               row_in   = 2'd0;
               ax_in    = 2'd0;
               acc_in   = 49'sd0;
               state_in = S_TR_MUL;
            end else begin
               cnt_in   = cnt_ff + 6'd1;
               state_in = S_PR_MUL;
            end
         end
         S_TR_MUL: state_in = S_TR_ACC;
         S_TR_ACC: begin
            acc_in = acc_ff + 49'(prod_ff);
            if (ax_ff == AX_LAST) begin
               state_in = S_TR_END;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_TR_MUL;
            end
         end
         S_TR_END: begin
            t_in[row_ff] = sat32(tv);
            ax_in        = 2'd0;
            acc_in       = 49'sd0;
            if (row_ff == AX_LAST) begin
               state_in = S_OUT;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = S_TR_MUL;
            end
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Register writes must arrive only while idle, so they never race the sequence; the block does not enforce it.
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED:   speed_in  = csr_wdata[15:0];
            CSR_START_X: pos_in[0] = signed'(csr_wdata);
            CSR_START_Y: pos_in[1] = signed'(csr_wdata);
            CSR_START_Z: pos_in[2] = signed'(csr_wdata);
            default:     speed_in  = speed_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         speed_ff <= SPEED_RESET;
         pitch_ff <= 16'd0;
         yaw_ff   <= 16'd0;
         pos_ff   <= '{default: 32'sd0};
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      row_ff   <= row_in;
      cnt_ff   <= cnt_in;
      dt_ff    <= dt_in;
      dir_ff   <= dir_in;
      sq_ff    <= sq_in;
      scale_ff <= scale_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      drem_ff  <= drem_in;
      dquo_ff  <= dquo_in;
      prod_ff  <= prod_in;
      sp_ff    <= sp_in;
      cp_ff    <= cp_in;
      sy_ff    <= sy_in;
      cy_ff    <= cy_in;
      rowm_ff  <= rowm_in;
      acc_ff   <= acc_in;
      t_ff     <= t_in;
   end

   assign rsp_ch.word.m00 = rowm_ff[0];
   assign rsp_ch.word.m01 = rowm_ff[1];
   assign rsp_ch.word.m02 = rowm_ff[2];
   assign rsp_ch.word.tx  = t_ff[0];
   assign rsp_ch.word.m10 = rowm_ff[3];
   assign rsp_ch.word.m11 = rowm_ff[4];
   assign rsp_ch.word.m12 = rowm_ff[5];
   assign rsp_ch.word.ty  = t_ff[1];
   assign rsp_ch.word.m20 = rowm_ff[6];
   assign rsp_ch.word.m21 = rowm_ff[7];
   assign rsp_ch.word.m22 = rowm_ff[8];
   assign rsp_ch.word.tz  = t_ff[2];

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("request taken while a response word is pending");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> req_ch.ready)
      else $error("block not idle after its response word was taken");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.word.m01 == 16'sd0))
      else $error("unused matrix entry is not zero");

   a_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_AX_DIV) |-> (root_ff[23:0] != 24'd0))
      else $error("division by a zero direction length");

endmodule

[test/cvu_view_checker.sv]
// ---------------------------------------------------------------------------
// cvu_view_checker
// Watches the request, response and register ports of the camera view update
// block, predicts every view matrix word and compares each one as it is taken.
// ---------------------------------------------------------------------------
module cvu_view_checker
   import cvu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   cvu_req_if                   req_ch,
   cvu_rsp_if                   rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   fails,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004760, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};
   localparam longint GAIN_Q30 = 652032874;

   logic [15:0]        cam_speed;
   logic signed [31:0] cam_x, cam_y, cam_z;
   logic [15:0]        cam_pitch, cam_yaw;
   rsp_word_type       view_q[$];

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint to_q14(longint v);
      longint q;
      q = (v + 32768) >>> 16;
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return q;
   endfunction

   task automatic angle_sin_cos(input logic [15:0] ang, output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      z = longint'({ang, 16'h0000});
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
      if (z > 64'sd1073741824) begin
         z = z - 64'sd2147483648;
         flip = 1;
      end else if (z < -64'sd1073741824) begin
         z = z + 64'sd2147483648;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TURNS[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TURNS[i];
         end
         x = nx;
      end
      c = to_q14(x);
      s = to_q14(y);
      if (flip) begin
         c = -c;
         s = -s;
      end
   endtask

   function automatic longint prod_q14(longint a, longint b);
      return (a * b + 8192) >>> 14;
   endfunction

   function automatic logic [31:0] row_offset(longint a, longint b, longint c);
      longint d;
      d = a * longint'(cam_x) + b * longint'(cam_y) + c * longint'(cam_z);
      return 32'(sat32((8192 - d) >>> 14));
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      fails++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report(what, got, want);
   endtask

   // Applies one request word to the camera and queues the matrix it causes.
   task automatic predict_view(input req_word_type w);
      longint d [3];
      longint len, scale, mag, sp, cp, sy, cy;
      longint r [9];
      bit     moved;
      rsp_word_type v;
      d[0] = longint'($signed(w.dir_x));
      d[1] = longint'($signed(w.dir_y));
      d[2] = longint'($signed(w.dir_z));
      moved = 0;
      if (d[0] != 0 || d[1] != 0 || d[2] != 0) begin
         len = root_floor((d[0] * d[0] + d[1] * d[1] + d[2] * d[2]) <<< 16);
         scale = longint'(w.delta_time) * longint'(cam_speed);
         for (int k = 0; k < 3; k++) begin
            mag = ((d[k] < 0) ? -d[k] : d[k]) * scale / len;
            d[k] = (d[k] < 0) ? -mag : mag;
         end
         cam_x = 32'(sat32(longint'(cam_x) + d[0]));
         cam_y = 32'(sat32(longint'(cam_y) + d[1]));
         cam_z = 32'(sat32(longint'(cam_z) + d[2]));
         moved = 1;
      end
      if (w.pitch_step != 0 || w.yaw_step != 0) begin
         cam_pitch = cam_pitch + w.pitch_step;
         cam_yaw   = cam_yaw + w.yaw_step;
         moved = 1;
      end
      if (moved) begin
         angle_sin_cos(cam_pitch, sp, cp);
         angle_sin_cos(cam_yaw, sy, cy);
         r[0] = cy;                r[1] = 0;   r[2] = -sy;
         r[3] = prod_q14(sy, sp);  r[4] = cp;  r[5] = prod_q14(cy, sp);
         r[6] = prod_q14(sy, cp);  r[7] = -sp; r[8] = prod_q14(cp, cy);
         v.m00 = 16'(r[0]); v.m01 = 16'(r[1]); v.m02 = 16'(r[2]);
         v.m10 = 16'(r[3]); v.m11 = 16'(r[4]); v.m12 = 16'(r[5]);
         v.m20 = 16'(r[6]); v.m21 = 16'(r[7]); v.m22 = 16'(r[8]);
         v.tx = row_offset(r[0], r[1], r[2]);
         v.ty = row_offset(r[3], r[4], r[5]);
         v.tz = row_offset(r[6], r[7], r[8]);
         view_q.push_back(v);
      end
   endtask

   task automatic check_view(input rsp_word_type g);
      rsp_word_type e;
      if (view_q.size() == 0) begin
         $display("unexpected view word %h at %0t", g, $realtime);
         fails++;
      end else begin
         e = view_q.pop_front();
         compare_field("m00", 32'(g.m00), 32'(e.m00));
         compare_field("m01", 32'(g.m01), 32'(e.m01));
         compare_field("m02", 32'(g.m02), 32'(e.m02));
         compare_field("tx", g.tx, e.tx);
         compare_field("m10", 32'(g.m10), 32'(e.m10));
         compare_field("m11", 32'(g.m11), 32'(e.m11));
         compare_field("m12", 32'(g.m12), 32'(e.m12));
         compare_field("ty", g.ty, e.ty);
         compare_field("m20", 32'(g.m20), 32'(e.m20));
         compare_field("m21", 32'(g.m21), 32'(e.m21));
         compare_field("m22", 32'(g.m22), 32'(e.m22));
         compare_field("tz", g.tz, e.tz);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cam_speed = SPEED_RESET;
         cam_x = 0; cam_y = 0; cam_z = 0;
         cam_pitch = 0; cam_yaw = 0;
         view_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_view(rsp_ch.word);
         if (csr_we) begin
            case (csr_index)
               CSR_SPEED:   cam_speed = csr_wdata[15:0];
               CSR_START_X: cam_x = $signed(csr_wdata);
               CSR_START_Y: cam_y = $signed(csr_wdata);
               CSR_START_Z: cam_z = $signed(csr_wdata);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) predict_view(req_ch.word);
      end
      pending = view_q.size();
   end

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Camera view update testbench: directed and random camera moves and turns
// under several speed and start settings, with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb;
   import cvu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   int                   fails;
   int                   pending;
   int                   views_taken;
   bit                   gaps_on;
   bit                   long_hold_done;

   cvu_req_if req_ch ();
   cvu_rsp_if rsp_ch ();

   camera_view_update dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   cvu_view_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fails(fails), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 96) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Values near the ends of the range and near zero turn up far more often than by chance.
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0001;
         3: return 16'hFFFF;
         4: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_word_type random_update(input bit quiet);
      req_word_type w;
      int kind;
      w.delta_time = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
      w.dir_x = 0; w.dir_y = 0; w.dir_z = 0;
      w.pitch_step = 0; w.yaw_step = 0;
      kind = $urandom_range(0, 9);
      if (!quiet && kind >= 3) begin
         w.dir_x = pick16(); w.dir_y = pick16(); w.dir_z = pick16();
         if ($urandom_range(0, 3) == 0) w.dir_y = 0;
      end
      if (!quiet && kind <= 7) begin
         w.pitch_step = pick16();
         w.yaw_step = ($urandom_range(0, 4) == 0) ? 16'h0000 : pick16();
      end
      return w;
   endfunction

   task automatic send_update(input req_word_type w);
      int g;
      req_ch.word  <= w;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_dir(input logic [15:0] dt, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic [15:0] p, input logic [15:0] q);
      req_word_type w;
      w.delta_time = dt; w.dir_x = x; w.dir_y = y; w.dir_z = z;
      w.pitch_step = p; w.yaw_step = q;
      send_update(w);
   endtask

   // Leaves write enable high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_camera(input logic [15:0] spd, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
      write_reg(CSR_SPEED, {16'h0000, spd});
      write_reg(CSR_START_X, x);
      write_reg(CSR_START_Y, y);
      write_reg(CSR_START_Z, z);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      req_word_type w;
      int sent;
      sent = 0;
      while (sent < n) begin
         w = random_update($urandom_range(0, 19) == 0);
         send_update(w);
         if (w.dir_x != 0 || w.dir_y != 0 || w.dir_z != 0 ||
             w.pitch_step != 0 || w.yaw_step != 0) sent++;
      end
   endtask

   // Response side: random stalls, and once a long hold-off that backs the
   // block up while the sender keeps offering words.
   initial begin
      int g;
      rsp_ch.ready <= 1'b0;
      views_taken = 0;
      long_hold_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) views_taken++;
         if (!long_hold_done && views_taken >= 40) begin
            long_hold_done = 1;
            rsp_ch.ready <= 1'b0;
            repeat (1500) @(posedge clock);
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (g) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= CSR_SPEED;
      csr_wdata    <= 32'h0;
      req_ch.valid <= 1'b0;
      req_ch.word  <= '0;
      gaps_on = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings.
      send_dir(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_dir(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
      send_dir(16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_dir(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      send_dir(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_dir(16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_dir(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000);
      send_dir(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
      send_dir(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'h8000);
      send_dir(16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'h2000, 16'hE000);
      send_dir(16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0001);
      send_dir(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F, 16'h3FFF, 16'hBFFF);
      settle();

      // Position near the positive and negative limits at top speed, so it saturates.
      set_camera(16'hFFFF, 32'h7FFF0000, 32'h80010000, 32'h7FFFFFFF);
      send_dir(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
      send_dir(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1000, 16'h0000);
      send_dir(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_dir(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h2000);
      random_phase(400);
      settle();

      gaps_on = 0;
      set_camera(16'h0000, 32'h80000000, 32'h00000000, 32'hFFFFFFFF);
      random_phase(350);
      settle();

      gaps_on = 1;
      set_camera(16'h0100, 32'h00000000, 32'h00000000, 32'h00000000);
      random_phase(450);
      settle();

      set_camera(16'($urandom), $urandom, $urandom, $urandom);
      random_phase(450);
      settle();

      if (fails == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
